// ===== src/fdc_pkg.sv =====
package fdc_pkg;

   // Table and attribute geometry.
   localparam int MAX_DEPENDENCIES = 16;
   localparam int ATTRIBUTE_COUNT  = 52;
   localparam int DEP_IDX_W        = (MAX_DEPENDENCIES > 1) ? $clog2(MAX_DEPENDENCIES) : 1;
   localparam int DEP_CNT_W        = $clog2(MAX_DEPENDENCIES + 1);

   // Field widths of the channels.
   localparam int ENTRY_INDEX_W = 4;
   localparam int COUNT_FIELD_W = 5;

   // Request command codes.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [ATTRIBUTE_COUNT-1:0] attr_mask_type;

   // One dependency as stored in the table memory.
   typedef struct packed {
      attr_mask_type left_mask;
      attr_mask_type right_mask;
   } dep_entry_type;

   // Write port of the table memory.
   typedef struct packed {
      logic           en;
      logic [DEP_IDX_W-1:0] addr;
      dep_entry_type  entry;
   } ram_wr_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic          scanning;
      logic          done;
      attr_mask_type closure;
   } eng_status_type;

   typedef enum logic [1:0] {
      FDC_IDLE,
      FDC_SCAN,
      FDC_DONE
   } fdc_state_type;

endpackage

// ===== src/fdc_req_if.sv =====
interface fdc_req_if import fdc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [ENTRY_INDEX_W-1:0]   entry_index;
   logic [ATTRIBUTE_COUNT-1:0] left_mask;
   logic [ATTRIBUTE_COUNT-1:0] right_mask;
   logic [ATTRIBUTE_COUNT-1:0] start_mask;

   modport source (
      output valid, command, entry_index, left_mask, right_mask, start_mask,
      input  ready
   );
   modport sink (
      input  valid, command, entry_index, left_mask, right_mask, start_mask,
      output ready
   );
endinterface

// ===== src/fdc_rsp_if.sv =====
interface fdc_rsp_if import fdc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ATTRIBUTE_COUNT-1:0] closure_mask;

   modport source (
      output valid, closure_mask,
      input  ready
   );
   modport sink (
      input  valid, closure_mask,
      output ready
   );
endinterface

// ===== src/fdc_csr_if.sv =====
interface fdc_csr_if import fdc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [COUNT_FIELD_W-1:0] dependency_count;

   modport source (
      output valid, dependency_count,
      input  ready
   );
   modport sink (
      input  valid, dependency_count,
      output ready
   );
endinterface

// ===== src/fdc_dep_ram.sv =====
module fdc_dep_ram import fdc_pkg::*; (
   input  logic                 clock,
   input  ram_wr_type           ram_wr,
   input  logic [DEP_IDX_W-1:0] rd_addr,
   output dep_entry_type        rd_data_ff
);

   dep_entry_type dep_mem_ff [MAX_DEPENDENCIES];

   // Single write port.
   always_ff @(posedge clock) begin
      if (ram_wr.en) begin
         dep_mem_ff[ram_wr.addr] <= ram_wr.entry;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= dep_mem_ff[rd_addr];
   end

endmodule

// ===== src/fdc_closure_seq.sv =====
module fdc_closure_seq import fdc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic [ENTRY_INDEX_W-1:0] req_entry_index,
   input  attr_mask_type            req_left_mask,
   input  attr_mask_type            req_right_mask,
   input  attr_mask_type            req_start_mask,
   input  logic [DEP_CNT_W-1:0]     dep_count,
   input  logic                     slot_free,
   output ram_wr_type               ram_wr,
   output logic [DEP_IDX_W-1:0]     rd_addr,
   input  dep_entry_type            rd_data,
   output eng_status_type           eng_stat
);

   fdc_state_type        state_ff, state_in;
   logic [DEP_IDX_W-1:0] entry_ff, entry_in;
   logic                 changed_ff, changed_in;
   attr_mask_type        cur_ff, cur_in;

   logic                 fire;
   logic                 last;
   logic [DEP_IDX_W-1:0] next_idx;
   attr_mask_type        grown;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FDC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scan position and the closure being built.
   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      changed_ff <= changed_in;
      cur_ff     <= cur_in;
   end

   // The entry read last cycle fires when its left side lies within the closure.
   assign fire     = (rd_data.left_mask & ~cur_ff) == '0;
   assign grown    = fire ? (cur_ff | rd_data.right_mask) : cur_ff;
   assign last     = (DEP_CNT_W'(entry_ff) + DEP_CNT_W'(1)) == dep_count;
   assign next_idx = last ? '0 : entry_ff + DEP_IDX_W'(1);

   // Next state, memory accesses and request handshake.
   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      changed_in = changed_ff;
      cur_in     = cur_ff;
      req_ready  = 1'b0;
      ram_wr     = '0;
      rd_addr    = entry_ff;
      case (state_ff)
         FDC_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  // Loads beyond the table are dropped.
                  ram_wr.en    = 32'(req_entry_index) < 32'(MAX_DEPENDENCIES);
                  ram_wr.addr  = DEP_IDX_W'(req_entry_index);
                  ram_wr.entry = '{left_mask: req_left_mask, right_mask: req_right_mask};
               end else begin
                  cur_in     = req_start_mask;
                  entry_in   = '0;
                  changed_in = 1'b0;
                  rd_addr    = '0;
                  state_in   = (dep_count == '0) ? FDC_DONE : FDC_SCAN;
               end
            end
         end
         FDC_SCAN: begin
            cur_in   = grown;
            rd_addr  = next_idx;
            entry_in = next_idx;
            if (last) begin
               // A pass that added nothing ends the query.
               changed_in = 1'b0;
               if (!changed_ff && (grown == cur_ff)) begin
                  state_in = FDC_DONE;
               end
            end else begin
               changed_in = changed_ff | (grown != cur_ff);
            end
         end
         FDC_DONE: begin
            if (slot_free) begin
               state_in = FDC_IDLE;
            end
         end
         default: begin
            state_in = FDC_IDLE;
         end
      endcase
   end

   assign eng_stat.scanning = state_ff == FDC_SCAN;
   assign eng_stat.done     = state_ff == FDC_DONE;
   assign eng_stat.closure  = cur_ff;

endmodule

// ===== src/functional_dependency_closure.sv =====
// Channel    Port      Moves                                               Handshake
// request    req_chan  load (entry_index, left_mask, right_mask) or query   valid/ready
// result     rsp_chan  closure_mask, one per query                         valid/ready
// register   csr_chan  dependency_count                                    valid/ready
//
// A query scans the table in passes, at most count + 1 of them, where count is
// dependency_count: the table memory's single read port delivers one dependency
// per cycle, and a pass with no growth ends the query.
// Synchronous active-high reset clears the control state and sets dependency_count
// to zero; the table memory holds no reset value and needs no clearing pass.
// A finished closure waits in the output register while loads keep being taken.
module functional_dependency_closure import fdc_pkg::*; (
   input logic     clock,
   input logic     reset,
   fdc_req_if.sink   req_chan,
   fdc_rsp_if.source rsp_chan,
   fdc_csr_if.sink   csr_chan
);

   logic [DEP_CNT_W-1:0] dep_count_ff, dep_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   attr_mask_type        closure_ff, closure_in;

   logic                 slot_free;
   ram_wr_type           ram_wr;
   logic [DEP_IDX_W-1:0] rd_addr;
   dep_entry_type        rd_data;
   eng_status_type       eng_stat;

   // Dependency count register, saturated to the table depth.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      dep_count_in = dep_count_ff;
      if (csr_chan.valid) begin
         if (32'(csr_chan.dependency_count) > 32'(MAX_DEPENDENCIES)) begin
            dep_count_in = DEP_CNT_W'(MAX_DEPENDENCIES);
         end else begin
            dep_count_in = DEP_CNT_W'(csr_chan.dependency_count);
         end
      end
   end

   // Output register between the sequencer and the result channel.
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      closure_in   = closure_ff;
      if (eng_stat.done && slot_free) begin
         rsp_valid_in = 1'b1;
         closure_in   = eng_stat.closure;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dep_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dep_count_ff <= dep_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      closure_ff <= closure_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.closure_mask = closure_ff;

   // Dependency table memory.
   fdc_dep_ram u_dep_ram (
      .clock      (clock),
      .ram_wr     (ram_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Closure sequencer.
   fdc_closure_seq u_closure_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_command     (req_chan.command),
      .req_entry_index (req_chan.entry_index),
      .req_left_mask   (req_chan.left_mask),
      .req_right_mask  (req_chan.right_mask),
      .req_start_mask  (req_chan.start_mask),
      .dep_count       (dep_count_ff),
      .slot_free       (slot_free),
      .ram_wr          (ram_wr),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .eng_stat        (eng_stat)
   );

`ifndef SYNTHESIS
   // A query holds off further requests in the next cycle.
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.command == CMD_QUERY)
      |=> !req_chan.ready)
      else $error("request taken right after a query");

   // A result appears only after the sequencer finished a query.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(eng_stat.done))
      else $error("result without a finished query");

   // The closure never loses an attribute while scanning.
   a_closure_grows: assert property (@(posedge clock) disable iff (reset)
      (eng_stat.scanning && $past(eng_stat.scanning))
      |-> (($past(eng_stat.closure) & ~eng_stat.closure) == '0))
      else $error("closure lost an attribute");
`endif

endmodule
